[sv/vcr_pkg.sv]
// Package for the value to color ramp block.
// Holds widths, register and code constants, the pipeline stage type and the blend function.
// Used by sv/value_to_color_ramp_top.sv.
package vcr_pkg;

  localparam int MAX_COLORS   = 16;
  localparam int CHANNEL_BITS = 8;
  localparam int FRAC_BITS    = 8;

  localparam int IDX_W    = $clog2(MAX_COLORS);
  localparam int COLOR_W  = 3 * CHANNEL_BITS;
  localparam int CNT_W    = 5;
  localparam int SAMPLE_W = 16;
  localparam int SPAN_W   = 16;
  localparam int Q_W      = IDX_W + FRAC_BITS + 1;
  localparam int NUM_W    = SPAN_W + Q_W - 1;
  localparam int BLEND_W  = CHANNEL_BITS + FRAC_BITS + 1;

  localparam int DIV_STAGES = Q_W;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH  = 2'd1;
  localparam logic [1:0] REG_COLOR_COUNT = 2'd2;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_MAP   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    FLAG_IN    = 2'd0,
    FLAG_ABOVE = 2'd1,
    FLAG_BELOW = 2'd2
  } flag_t;

  typedef struct packed {
    kind_t                  kind;
    logic [IDX_W-1:0]       idx;
    logic [COLOR_W-1:0]     color;
    flag_t                  flag;
    logic [CNT_W-1:0]       cnt;
    logic [SPAN_W-1:0]      span;
    logic [NUM_W-1:0]       rem;
    logic [Q_W-1:0]         quo;
  } div_stage_t;

  function automatic logic [CHANNEL_BITS-1:0] blend(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b,
    input logic [FRAC_BITS-1:0]    f
  );
    logic [FRAC_BITS:0]   w;
    logic [BLEND_W-1:0]   s;
    w = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, f};
    s = BLEND_W'(a) * BLEND_W'(w) + BLEND_W'(b) * BLEND_W'(f)
        + BLEND_W'(1 << (FRAC_BITS - 1));
    return s[FRAC_BITS +: CHANNEL_BITS];
  endfunction

endpackage

[sv/value_to_color_ramp_top.sv]
// Top level of the value to color ramp block: config port, divider pipeline,
// palette memory and blend stage. Depends on sv/vcr_pkg.sv.
//
// Usage: the input stream carries one item per transfer. s_tuser selects the
// kind: a palette write (entry_index, entry_color) or a map item (sample).
// A map item yields one result transfer on the output stream with red, green,
// blue in m_tdata and the range flag in m_tuser; a palette write yields none.
// The range registers and the palette size are written through the APB port
// while the stream is idle.
// Pipeline: a map item passes one setup stage, 13 quotient stages of one bit
// each, one palette read stage and one blend stage. Throughput is one item per
// clock while the receiver does not stall.
// The palette memory is written and read in the same stage, so items keep
// their order without forwarding.
// Reset empties all stages and loads the range and size registers; the palette
// contents are undefined until written.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling bubbles until the pipeline is full; only then
// does s_tready fall.
module value_to_color_ramp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // entry_index[3:0], entry_color[27:4], sample[43:28], zeros
  input  logic        s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic [1:0]  m_tuser,   // range_flag[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [vcr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [vcr_pkg::SAMPLE_W-1:0] range_low;
  logic signed [vcr_pkg::SAMPLE_W-1:0] range_high;
  logic [vcr_pkg::CNT_W-1:0]           color_count;
  logic [1:0]                          reg_idx;

  logic signed [vcr_pkg::SAMPLE_W:0]   lo_x;
  logic signed [vcr_pkg::SAMPLE_W:0]   hi_x;
  logic signed [vcr_pkg::SAMPLE_W:0]   lo_o;
  logic signed [vcr_pkg::SAMPLE_W:0]   hi_o;
  logic signed [vcr_pkg::SAMPLE_W:0]   smp_x;
  logic signed [vcr_pkg::SAMPLE_W:0]   diff;
  logic [vcr_pkg::CNT_W-1:0]           cnt_eff;
  logic [vcr_pkg::NUM_W-vcr_pkg::FRAC_BITS-1:0] prod;
  vcr_pkg::div_stage_t                 in_stg;

  vcr_pkg::div_stage_t st  [0:vcr_pkg::DIV_STAGES];
  logic                vld [0:vcr_pkg::DIV_STAGES];
  logic                rdy [0:vcr_pkg::DIV_STAGES];

  logic [vcr_pkg::COLOR_W-1:0] palette [0:vcr_pkg::MAX_COLORS-1];
  logic [vcr_pkg::CNT_W-1:0]   seg;
  logic                        last_seg;
  logic [vcr_pkg::IDX_W-1:0]   addr_a;
  logic [vcr_pkg::IDX_W-1:0]   addr_b;
  logic [vcr_pkg::FRAC_BITS-1:0] frac_sel;

  logic                          mem_vld;
  logic                          mem_rdy;
  vcr_pkg::flag_t                mem_flag;
  logic [vcr_pkg::FRAC_BITS-1:0] mem_frac;
  logic [vcr_pkg::COLOR_W-1:0]   rd_a;
  logic [vcr_pkg::COLOR_W-1:0]   rd_b;
  logic                          out_rdy;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= '0;
      range_high  <= 16'sh7FFF;
      color_count <= vcr_pkg::CNT_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        vcr_pkg::REG_RANGE_LOW:   range_low   <= pwdata[vcr_pkg::SAMPLE_W-1:0];
        vcr_pkg::REG_RANGE_HIGH:  range_high  <= pwdata[vcr_pkg::SAMPLE_W-1:0];
        vcr_pkg::REG_COLOR_COUNT: color_count <= pwdata[vcr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vcr_pkg::REG_RANGE_LOW:   prdata = {16'd0, range_low};
      vcr_pkg::REG_RANGE_HIGH:  prdata = {16'd0, range_high};
      vcr_pkg::REG_COLOR_COUNT: prdata = {27'd0, color_count};
      default:                  prdata = '0;
    endcase
  end

  // Setup stage: order the range, classify the sample and form the dividend.
  always_comb begin
    lo_x  = {range_low[vcr_pkg::SAMPLE_W-1], range_low};
    hi_x  = {range_high[vcr_pkg::SAMPLE_W-1], range_high};
    smp_x = {s_tdata[43], s_tdata[43:28]};
    if (lo_x > hi_x) begin
      lo_o = hi_x;
      hi_o = lo_x;
    end else begin
      lo_o = lo_x;
      hi_o = hi_x;
    end
    if (lo_o == hi_o) begin
      hi_o = lo_o + 17'sd1;
    end
    if (color_count == '0) begin
      cnt_eff = vcr_pkg::CNT_W'(1);
    end else if (color_count > vcr_pkg::CNT_W'(vcr_pkg::MAX_COLORS)) begin
      cnt_eff = vcr_pkg::CNT_W'(vcr_pkg::MAX_COLORS);
    end else begin
      cnt_eff = color_count;
    end
    diff = smp_x - lo_o;
    prod = (vcr_pkg::NUM_W - vcr_pkg::FRAC_BITS)'(diff[vcr_pkg::SPAN_W-1:0])
         * (vcr_pkg::NUM_W - vcr_pkg::FRAC_BITS)'(cnt_eff);

    in_stg.kind  = vcr_pkg::kind_t'(s_tuser);
    in_stg.idx   = s_tdata[3:0];
    in_stg.color = s_tdata[27:4];
    in_stg.cnt   = cnt_eff;
    in_stg.span  = vcr_pkg::SPAN_W'(hi_o - lo_o);
    in_stg.rem   = {prod, vcr_pkg::FRAC_BITS'(0)};
    in_stg.quo   = '0;
    if (smp_x > hi_o) begin
      in_stg.flag = vcr_pkg::FLAG_ABOVE;
    end else if (smp_x < lo_o) begin
      in_stg.flag = vcr_pkg::FLAG_BELOW;
    end else begin
      in_stg.flag = vcr_pkg::FLAG_IN;
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st[0] <= in_stg;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar i = 1; i <= vcr_pkg::DIV_STAGES; i++) begin : g_div
    localparam int J = vcr_pkg::DIV_STAGES - i;
    logic [vcr_pkg::NUM_W-1:0] dvs;
    logic                      ge;
    vcr_pkg::div_stage_t       nxt;

    assign dvs = vcr_pkg::NUM_W'(st[i-1].span) << J;
    assign ge  = st[i-1].rem >= dvs;

    always_comb begin
      nxt = st[i-1];
      if (ge) begin
        nxt.rem    = st[i-1].rem - dvs;
        nxt.quo[J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        st[i] <= nxt;
      end
    end
  end

  for (genvar i = 0; i < vcr_pkg::DIV_STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end
  assign rdy[vcr_pkg::DIV_STAGES] = !vld[vcr_pkg::DIV_STAGES] || mem_rdy;

  // Palette stage: segment select, palette write and two-port read.
  always_comb begin
    seg      = st[vcr_pkg::DIV_STAGES].quo[vcr_pkg::Q_W-1:vcr_pkg::FRAC_BITS];
    last_seg = seg >= (st[vcr_pkg::DIV_STAGES].cnt - vcr_pkg::CNT_W'(1));
    if (last_seg) begin
      addr_a   = vcr_pkg::IDX_W'(st[vcr_pkg::DIV_STAGES].cnt - vcr_pkg::CNT_W'(1));
      addr_b   = vcr_pkg::IDX_W'(st[vcr_pkg::DIV_STAGES].cnt - vcr_pkg::CNT_W'(1));
      frac_sel = '0;
    end else begin
      addr_a   = seg[vcr_pkg::IDX_W-1:0];
      addr_b   = seg[vcr_pkg::IDX_W-1:0] + vcr_pkg::IDX_W'(1);
      frac_sel = st[vcr_pkg::DIV_STAGES].quo[vcr_pkg::FRAC_BITS-1:0];
    end
  end

  assign mem_rdy = !mem_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (mem_rdy && vld[vcr_pkg::DIV_STAGES]
        && st[vcr_pkg::DIV_STAGES].kind == vcr_pkg::KIND_WRITE) begin
      palette[st[vcr_pkg::DIV_STAGES].idx] <= st[vcr_pkg::DIV_STAGES].color;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rdy) begin
      rd_a     <= palette[addr_a];
      rd_b     <= palette[addr_b];
      mem_flag <= st[vcr_pkg::DIV_STAGES].flag;
      mem_frac <= frac_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= 1'b0;
    end else if (mem_rdy) begin
      mem_vld <= vld[vcr_pkg::DIV_STAGES]
                 && st[vcr_pkg::DIV_STAGES].kind == vcr_pkg::KIND_MAP;
    end
  end

  // Blend stage and output register.
  assign out_rdy = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_rdy) begin
      m_tvalid <= mem_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      m_tuser <= mem_flag;
      case (mem_flag)
        vcr_pkg::FLAG_ABOVE: m_tdata <= '1;
        vcr_pkg::FLAG_BELOW: m_tdata <= '0;
        default: begin
          m_tdata[7:0]   <= vcr_pkg::blend(rd_a[23:16], rd_b[23:16], mem_frac);
          m_tdata[15:8]  <= vcr_pkg::blend(rd_a[15:8], rd_b[15:8], mem_frac);
          m_tdata[23:16] <= vcr_pkg::blend(rd_a[7:0], rd_b[7:0], mem_frac);
        end
      endcase
    end
  end

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[vcr_pkg::DIV_STAGES] && st[vcr_pkg::DIV_STAGES].kind == vcr_pkg::KIND_MAP
    && st[vcr_pkg::DIV_STAGES].flag == vcr_pkg::FLAG_IN
    |-> st[vcr_pkg::DIV_STAGES].quo <= {st[vcr_pkg::DIV_STAGES].cnt,
                                        vcr_pkg::FRAC_BITS'(0)})
    else $error("segment quotient exceeds palette size");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[vcr_pkg::DIV_STAGES] && st[vcr_pkg::DIV_STAGES].kind == vcr_pkg::KIND_MAP
    && st[vcr_pkg::DIV_STAGES].flag == vcr_pkg::FLAG_IN
    |-> st[vcr_pkg::DIV_STAGES].rem < vcr_pkg::NUM_W'(st[vcr_pkg::DIV_STAGES].span))
    else $error("divider remainder not below divisor");

  a_above_white: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == vcr_pkg::FLAG_ABOVE |-> m_tdata == 24'hFFFFFF)
    else $error("above-range result is not white");

  a_below_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == vcr_pkg::FLAG_BELOW |-> m_tdata == 24'h000000)
    else $error("below-range result is not black");

endmodule

[tb/testbench.sv]
// Self-checking bench for value_to_color_ramp_top: palette writes and mapped samples
// go through the input stream, an in-bench color ramp predictor scores every result.
// Depends on sv/vcr_pkg.sv and sv/value_to_color_ramp_top.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP = 13;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    vcr_pkg::kind_t     kind;
    logic [3:0]         idx;
    logic [23:0]        color;
    logic signed [15:0] sample;
  } ramp_item_t;

  typedef struct {
    logic [7:0]     red;
    logic [7:0]     green;
    logic [7:0]     blue;
    vcr_pkg::flag_t flag;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;  // entry_index[3:0], entry_color[27:4], sample[43:28], zeros
  logic s_tuser = 1'b0;       // kind[0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;       // red[7:0], green[15:8], blue[23:16]
  logic [1:0] m_tuser;        // range_flag[1:0]
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [vcr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  value_to_color_ramp_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  logic signed [15:0] cfg_low = 16'sd0;
  logic signed [15:0] cfg_high = 16'sd32767;
  logic [4:0] cfg_count = 5'd1;
  logic [23:0] palette_shadow [vcr_pkg::MAX_COLORS];

  ramp_item_t ramp_items [$];
  pixel_t expected_pixels [$];
  ramp_item_t cur_item;
  bit presenting = 0;
  bit s_done = 0;
  bit m_done = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;
  bit m_hold = 0;
  bit hold_request = 0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int cycle_count = 0;
  pixel_t want_px;
  pixel_t got_px;

  logic [23:0] seed_colors [8] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                   24'h0000FF, 24'h808080, 24'h123456, 24'hFEDCBA};

  function automatic pixel_t ramp_color(input logic signed [15:0] v);
    int lo, hi, tmp, cnt, vi, d, span, p, f, s;
    longint q;
    logic [23:0] ea, eb;
    logic [7:0] ch [3];
    pixel_t r;
    lo = cfg_low;
    hi = cfg_high;
    vi = v;
    if (lo > hi) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    if (lo == hi) hi = lo + 1;
    cnt = cfg_count;
    if (cnt == 0) cnt = 1;
    if (cnt > vcr_pkg::MAX_COLORS) cnt = vcr_pkg::MAX_COLORS;
    if (vi > hi) begin
      r = '{8'hFF, 8'hFF, 8'hFF, vcr_pkg::FLAG_ABOVE};
      return r;
    end
    if (vi < lo) begin
      r = '{8'h00, 8'h00, 8'h00, vcr_pkg::FLAG_BELOW};
      return r;
    end
    d = vi - lo;
    span = hi - lo;
    q = (longint'(d) * cnt * 256) / span;
    p = int'(q / 256);
    f = int'(q % 256);
    if (p >= cnt - 1) begin
      ea = palette_shadow[cnt - 1];
      ch[0] = ea[23:16];
      ch[1] = ea[15:8];
      ch[2] = ea[7:0];
    end else begin
      ea = palette_shadow[p];
      eb = palette_shadow[p + 1];
      for (int k = 0; k < 3; k++) begin
        s = int'(ea[(2 - k) * 8 +: 8]) * (256 - f) + int'(eb[(2 - k) * 8 +: 8]) * f + 128;
        ch[k] = 8'(s >> 8);
      end
    end
    r = '{ch[0], ch[1], ch[2], vcr_pkg::FLAG_IN};
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(input int x);
    if (x > 32767) return 16'sd32767;
    if (x < -32768) return -16'sd32768;
    return 16'(x);
  endfunction

  // Input driver: one random gap before each item, with stretches of back-to-back transfers.
  always @(negedge clk) begin
    if (s_done) begin
      s_done = 0;
      presenting = 0;
      if ($urandom_range(0, 49) == 0) quiet_in = !quiet_in;
      gap_left = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (!presenting && !rst) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (ramp_items.size() != 0) begin
        cur_item = ramp_items.pop_front();
        presenting = 1;
      end
    end
    s_tvalid <= presenting;
    s_tdata <= {4'd0, cur_item.sample, cur_item.color, cur_item.idx};
    s_tuser <= cur_item.kind;
  end

  // Output receiver: a random stall after each transfer, plus the long hold-off.
  always @(negedge clk) begin
    if (m_done) begin
      m_done = 0;
      if ($urandom_range(0, 49) == 0) quiet_out = !quiet_out;
      stall_left = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
    end
    if (m_hold) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 0;
      m_hold = 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      m_hold = 0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (vcr_pkg::kind_t'(s_tuser) == vcr_pkg::KIND_WRITE) begin
          palette_shadow[s_tdata[3:0]] = s_tdata[27:4];
        end else begin
          expected_pixels.insert(expected_pixels.size(), ramp_color(s_tdata[43:28]));
        end
        s_done = 1;
      end
      if (m_tvalid && m_tready) begin
        m_done = 1;
        got_px = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], vcr_pkg::flag_t'(m_tuser)};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result rgb=%h flag=%0d", $realtime, m_tdata, m_tuser);
        end else begin
          want_px = expected_pixels.pop_front();
          if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
              got_px.blue !== want_px.blue || got_px.flag !== want_px.flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch, expected r=%h g=%h b=%h flag=%0d, got r=%h g=%h b=%h flag=%0d",
                       $realtime, want_px.red, want_px.green, want_px.blue, want_px.flag,
                       got_px.red, got_px.green, got_px.blue, got_px.flag);
          end
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_write(input logic [3:0] idx, input logic [23:0] color);
    ramp_item_t it;
    it = '{vcr_pkg::KIND_WRITE, idx, color, 16'($urandom)};
    ramp_items.insert(ramp_items.size(), it);
  endtask

  task automatic push_map(input logic signed [15:0] sample);
    ramp_item_t it;
    it = '{vcr_pkg::KIND_MAP, 4'($urandom), 24'($urandom), sample};
    ramp_items.insert(ramp_items.size(), it);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (ramp_items.size() != 0 || presenting || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_sel)
      vcr_pkg::REG_RANGE_LOW:   cfg_low = value[15:0];
      vcr_pkg::REG_RANGE_HIGH:  cfg_high = value[15:0];
      vcr_pkg::REG_COLOR_COUNT: cfg_count = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_range(input int lo, input int hi, input int cnt);
    wait_idle();
    apb_write(vcr_pkg::REG_RANGE_LOW, {16'd0, 16'(lo)});
    apb_write(vcr_pkg::REG_RANGE_HIGH, {16'd0, 16'(hi)});
    apb_write(vcr_pkg::REG_COLOR_COUNT, {27'd0, 5'(cnt)});
  endtask

  // Mostly in-range samples, with edges, full-scale noise and palette rewrites mixed in.
  task automatic queue_random(input int n);
    int lo, hi, pick;
    lo = cfg_low;
    hi = cfg_high;
    if (lo > hi) begin
      pick = lo;
      lo = hi;
      hi = pick;
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        push_write(4'($urandom), 24'($urandom));
      end else if (pick < 20) begin
        push_map(16'($urandom));
      end else if (pick < 35) begin
        case ($urandom_range(0, 7))
          0: push_map(clamp16(lo));
          1: push_map(clamp16(hi));
          2: push_map(clamp16(lo - 1));
          3: push_map(clamp16(hi + 1));
          4: push_map(clamp16(lo + 1));
          5: push_map(clamp16(hi - 1));
          6: push_map(-16'sd32768);
          default: push_map(16'sd32767);
        endcase
      end else begin
        push_map(clamp16(lo + int'($urandom_range(0, hi - lo))));
      end
    end
  endtask

  initial begin
    int lo;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < vcr_pkg::MAX_COLORS; i++)
      push_write(4'(i), (i < 8) ? seed_colors[i] : 24'($urandom));
    push_map(-16'sd32768);
    push_map(-16'sd1);
    push_map(16'sd0);
    push_map(16'sd16384);
    push_map(16'sd32767);

    set_range(-32768, 32767, 16);
    queue_random(150);
    set_range(1000, -1000, 5);
    queue_random(120);
    set_range(500, 500, 3);
    queue_random(80);
    set_range(-100, 200, 0);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    queue_random(120);
    set_range(32767, 32767, 31);
    queue_random(60);
    set_range(-32768, -32768, 2);
    queue_random(60);
    for (int ph = 0; ph < 3; ph++) begin
      set_range(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                $urandom_range(0, 31));
      queue_random(150);
    end
    lo = int'($urandom_range(0, 65535)) - 32768;
    set_range(lo, lo + int'($urandom_range(0, 40)), $urandom_range(1, 16));
    queue_random(100);

    set_range(0, 255, 16);
    hold_request = 1;
    queue_random(150);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
